>>> rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  localparam int DIV_W = 32;
  localparam int REQ_W = 24;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NOSPACE,
    STATUS_RANGE,
    STATUS_NOTALLOC
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_F_RD,
    ST_F_CHK,
    ST_M_RD,
    ST_M_V,
    ST_M_W,
    ST_M_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ffba_ram.sv
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ffba_div.sv
`default_nettype none

module ffba_div
  import ffba_pkg::*;
#(
  parameter int DIVISOR = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  output div_rsp_t              rsp
);

  // quotient by reciprocal multiplication, exact over the full dividend range
  localparam int SHIFT = DIV_W + $clog2(DIVISOR);
  localparam int PW = 2 * DIV_W + 1;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [DIV_W:0]   RECIP = RECIP_64[DIV_W:0];
  localparam logic [DIV_W-1:0] DIVISOR_C = DIV_W'(DIVISOR);

  logic [2:0]       stage;
  logic             done;
  logic [DIV_W-1:0] num;
  logic [PW-1:0]    prod;
  logic [DIV_W-1:0] quot;
  logic             rem_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (stage[0]) begin
      prod <= PW'(num) * PW'(RECIP);
    end
    if (stage[1]) begin
      quot <= DIV_W'(prod >> SHIFT);
    end
    if (stage[2]) begin
      rem_nz <= num != DIV_W'(quot * DIVISOR_C);
    end
  end

  assign rsp.done   = done;
  assign rsp.rem_nz = rem_nz;
  assign rsp.quot   = quot;

endmodule

`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
`default_nettype none
// allocate in blocks: runs are checked from the map start to the first fit, marked taken,
// split if larger; bytes are divided first; free: divide, read, release write, then a map
// walk merging each free run with free runs after it; out of range goes straight to done
// throughput: one item at a time, set by the map walk; the next item is taken while the
// result waits in the output register
// reset: synchronous; a clearing pass rewrites every map entry before in_ready

module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [31:0]      cfg_write_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             action,
  input  wire logic [REQ_W-1:0] request_size,
  input  wire logic             size_in_blocks,
  input  wire logic [31:0]      free_address,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [31:0]      granted_address,
  output logic      [1:0]       status
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = IW + 1;
  localparam int EW = $clog2(NUM_BLOCKS + 1) + 1;
  localparam logic [CW-1:0]  NB_C = CW'(NUM_BLOCKS);
  localparam logic [REQ_W:0] NB_REQ = (REQ_W + 1)'(NUM_BLOCKS);
  localparam logic [32:0]    HEAP_BYTES = 33'(NUM_BLOCKS * BLOCK_BYTES);
  localparam logic [31:0]    BB_W = 32'(BLOCK_BYTES);

  state_t        state, state_next;
  logic [31:0]   heap_base;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] nxt, nxt_next;
  logic [CW-1:0] acc, acc_next;
  logic [CW-1:0] size_blk, size_blk_next;
  logic [EW-1:0] split_val, split_val_next;
  logic          act, act_next;
  status_t       res_status, res_status_next;
  logic [31:0]   res_granted, res_granted_next;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  div_rsp_t         div_rsp;

  logic          load_out;
  logic          rd_neg;
  logic [EW-1:0] rd_abs;
  logic [CW-1:0] rd_mag;
  logic [CW-1:0] rd_step;
  logic          rd_pos;
  logic          rd_fit;
  logic [CW-1:0] idx_step;
  logic [CW-1:0] nxt_step;
  logic [CW-1:0] split_idx;
  logic [32:0]   heap_end;
  logic          range_bad;
  logic [31:0]   offset;
  logic [REQ_W:0] blk_in;
  logic [REQ_W:0] blk_div;

  ffba_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffba_div #(
    .DIVISOR (BLOCK_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .rsp      (div_rsp)
  );

  assign rd_neg    = ram_rdata[EW-1];
  assign rd_abs    = rd_neg ? ('0 - ram_rdata) : ram_rdata;
  assign rd_mag    = rd_abs[CW-1:0];
  assign rd_step   = (rd_mag == '0) ? CW'(1) : rd_mag;
  assign rd_pos    = !rd_neg && (rd_mag != '0);
  assign rd_fit    = !rd_neg && (rd_mag >= size_blk);
  assign idx_step  = idx + rd_step;
  assign nxt_step  = nxt + rd_mag;
  assign split_idx = idx + size_blk;

  assign heap_end  = {1'b0, heap_base} + HEAP_BYTES;
  assign range_bad = (free_address == '0) || (free_address < heap_base) ||
                     ({1'b0, free_address} >= heap_end);
  assign offset    = free_address - heap_base;
  assign blk_in    = {1'b0, request_size};
  assign blk_div   = div_rsp.quot[REQ_W:0] + (REQ_W + 1)'(div_rsp.rem_nz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      heap_base <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_write_en) begin
        heap_base <= cfg_write_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nxt         <= nxt_next;
    acc         <= acc_next;
    size_blk    <= size_blk_next;
    split_val   <= split_val_next;
    act         <= act_next;
    res_status  <= res_status_next;
    res_granted <= res_granted_next;
    if (load_out) begin
      granted_address <= res_granted;
      status          <= res_status;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    nxt_next         = nxt;
    acc_next         = acc;
    size_blk_next    = size_blk;
    split_val_next   = split_val;
    act_next         = act;
    res_status_next  = res_status;
    res_granted_next = res_granted;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = '0;
    ram_raddr        = '0;
    div_start        = 1'b0;
    div_dividend     = '0;
    load_out         = 1'b0;
    in_ready         = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[IW-1:0];
        ram_wdata = (idx == '0) ? EW'(NUM_BLOCKS) : '0;
        if (idx == CW'(NUM_BLOCKS - 1)) begin
          idx_next   = '0;
          state_next = ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next         = action;
          res_granted_next = '0;
          idx_next         = '0;
          if (!action) begin
            if (size_in_blocks) begin
              if (blk_in != '0 && blk_in <= NB_REQ) begin
                size_blk_next = blk_in[CW-1:0];
                state_next    = ST_A_RD;
              end else begin
                res_status_next = STATUS_NOSPACE;
                state_next      = ST_DONE;
              end
            end else begin
              div_start    = 1'b1;
              div_dividend = DIV_W'(request_size);
              state_next   = ST_DIV;
            end
          end else if (range_bad) begin
            res_status_next = STATUS_RANGE;
            state_next      = ST_DONE;
          end else begin
            div_start    = 1'b1;
            div_dividend = offset;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (!act) begin
            if (blk_div != '0 && blk_div <= NB_REQ) begin
              size_blk_next = blk_div[CW-1:0];
              state_next    = ST_A_RD;
            end else begin
              res_status_next = STATUS_NOSPACE;
              state_next      = ST_DONE;
            end
          end else if (div_rsp.quot >= DIV_W'(NUM_BLOCKS)) begin
            res_status_next = STATUS_NOTALLOC;
            state_next      = ST_DONE;
          end else begin
            idx_next   = CW'(div_rsp.quot[IW-1:0]);
            state_next = ST_F_RD;
          end
        end
      end
      ST_A_RD: begin
        if (idx >= NB_C) begin
          res_status_next = STATUS_NOSPACE;
          state_next      = ST_DONE;
        end else begin
          ram_raddr  = idx[IW-1:0];
          state_next = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (rd_fit) begin
          ram_we           = 1'b1;
          ram_waddr        = idx[IW-1:0];
          ram_wdata        = '0 - EW'(size_blk);
          res_granted_next = heap_base + BB_W * 32'(idx);
          res_status_next  = STATUS_OK;
          if (rd_mag > size_blk && split_idx < NB_C) begin
            split_val_next = EW'(rd_mag - size_blk);
            state_next     = ST_A_SPLIT;
          end else begin
            state_next = ST_DONE;
          end
        end else if (idx_step >= NB_C) begin
          res_status_next = STATUS_NOSPACE;
          state_next      = ST_DONE;
        end else begin
          ram_raddr = idx_step[IW-1:0];
          idx_next  = idx_step;
        end
      end
      ST_A_SPLIT: begin
        ram_we     = 1'b1;
        ram_waddr  = split_idx[IW-1:0];
        ram_wdata  = split_val;
        state_next = ST_DONE;
      end
      ST_F_RD: begin
        ram_raddr  = idx[IW-1:0];
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (!rd_neg) begin
          res_status_next = STATUS_NOTALLOC;
          state_next      = ST_DONE;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = idx[IW-1:0];
          ram_wdata  = rd_abs;
          idx_next   = '0;
          state_next = ST_M_RD;
        end
      end
      ST_M_RD: begin
        if (idx >= NB_C) begin
          res_status_next = STATUS_OK;
          state_next      = ST_DONE;
        end else begin
          ram_raddr  = idx[IW-1:0];
          state_next = ST_M_V;
        end
      end
      ST_M_V: begin
        if (rd_pos && idx_step < NB_C) begin
          ram_raddr  = idx_step[IW-1:0];
          nxt_next   = idx_step;
          acc_next   = rd_mag;
          state_next = ST_M_W;
        end else begin
          idx_next   = idx_step;
          state_next = ST_M_RD;
        end
      end
      ST_M_W: begin
        if (rd_pos) begin
          ram_we    = 1'b1;
          ram_waddr = nxt[IW-1:0];
          ram_wdata = '0;
          acc_next  = acc + rd_mag;
          if (nxt_step < NB_C) begin
            ram_raddr = nxt_step[IW-1:0];
            nxt_next  = nxt_step;
          end else begin
            state_next = ST_M_FIN;
          end
        end else begin
          state_next = ST_M_FIN;
        end
      end
      ST_M_FIN: begin
        ram_we     = 1'b1;
        ram_waddr  = idx[IW-1:0];
        ram_wdata  = EW'(acc);
        idx_next   = idx + acc;
        state_next = ST_M_RD;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> granted_address == '0)
    else $error("failed item carries a nonzero address");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the divide wait");

  a_size_legal: assert property (@(posedge clk) disable iff (rst)
    state == ST_A_CHK |-> size_blk != '0 && size_blk <= NB_C)
    else $error("allocate walk with illegal size");

  a_no_accept_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item accepted during map clearing");

endmodule

`default_nettype wire
